// ===== hw/rtl/assert_macros.svh =====
// Assertion macros included by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/bpsp_pkg.sv =====
// ----------------------------------------------------------------------------
// bpsp_pkg
// Shared constants, types and the CORDIC angle table of the baseline phasor.
// ----------------------------------------------------------------------------
`default_nettype none

package bpsp_pkg;

    localparam int CORDIC_STAGES     = 16;
    localparam int PHASE_FRAC_BITS   = 24;
    localparam int ATAN_ENTRIES      = 24;
    localparam int CORDIC_N          = (CORDIC_STAGES < ATAN_ENTRIES) ?
                                       CORDIC_STAGES : ATAN_ENTRIES;
    // Fractional bits of a u*l product (Q24.8 times Q1.30).
    localparam int PRODUCT_FRAC_BITS = 38;

    typedef logic signed [31:0] word_t;
    typedef logic signed [15:0] sample_t;
    typedef logic [PRODUCT_FRAC_BITS-1:0] prod_t;

    // Keeps the top PHASE_FRAC_BITS bits of the 32-bit turn word.
    localparam logic [31:0] PHASE_MASK =
        ~((32'd1 << (32 - PHASE_FRAC_BITS)) - 32'd1);

    localparam logic signed [32:0] ONE_Q30   = 33'sd1073741824;
    localparam logic signed [32:0] HALF_TURN = 33'sd2147483648;
    localparam word_t              CORDIC_X0 = 32'sd652032874;
    localparam logic signed [32:0] ROUND_Q15 = 33'sd16384;
    localparam logic signed [32:0] OUT_MAX   = 33'sd32767;

    // atan(2^-i) in units of 2^-32 turn.
    localparam word_t ATAN_TURNS [ATAN_ENTRIES] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    // Control that travels with each request down the pipeline.
    typedef struct packed {
        logic valid;
        logic neg;
    } bpsp_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/baseline_phase_shift_phasor.sv =====
// Baseline phase-shift phasor.
// Input channel (s_valid/s_ready): baseline u, v, w in Q24.8 wavelengths and
// direction cosines l, m, n in Q1.30. Result channel (m_valid/m_ready): the
// unit phasor cos and sin of 2*pi*(u*l + v*m + w*(n-1)) in Q1.15, saturated
// to +-32767.
// Pipeline from an accepted request to m_valid: two phase stages, one
// register per CORDIC micro-rotation, and the rounding output register.
// Throughput: one request per clock while s_ready is high; every pipeline
// stage holds an item. When the receiver stalls, the next finished result
// goes into a one-entry skid register and the whole pipeline then holds
// (s_ready low) until the skid register drains, so nothing is lost or repeated.
// s_ready comes straight from a flip-flop.
// Reset (aresetn low at a clock edge) clears every valid bit; no result
// is presented afterwards until a new request has passed the pipeline.
`default_nettype none

`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// baseline_phase_shift_phasor
// Top level: phase stages, pipelined CORDIC and output buffer.
// ----------------------------------------------------------------------------
module baseline_phase_shift_phasor (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic signed [31:0]  s_u_wavelengths,
    input  wire logic signed [31:0]  s_v_wavelengths,
    input  wire logic signed [31:0]  s_w_wavelengths,
    input  wire logic signed [31:0]  s_dir_l,
    input  wire logic signed [31:0]  s_dir_m,
    input  wire logic signed [31:0]  s_dir_n,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [15:0]       m_phasor_cos,
    output logic signed [15:0]       m_phasor_sin
);

    logic                pipe_en;
    bpsp_pkg::bpsp_ctl_t phase_ctl;
    bpsp_pkg::word_t     phase_z;
    bpsp_pkg::bpsp_ctl_t cordic_ctl;
    bpsp_pkg::word_t     cordic_x;
    bpsp_pkg::word_t     cordic_y;

    assign s_ready = pipe_en;

    bpsp_phase u_phase (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (pipe_en),
        .in_valid (s_valid),
        .u_in     (s_u_wavelengths),
        .v_in     (s_v_wavelengths),
        .w_in     (s_w_wavelengths),
        .l_in     (s_dir_l),
        .m_in     (s_dir_m),
        .n_in     (s_dir_n),
        .ctl_out  (phase_ctl),
        .z_out    (phase_z)
    );

    bpsp_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .ctl_in  (phase_ctl),
        .z_in    (phase_z),
        .ctl_out (cordic_ctl),
        .x_out   (cordic_x),
        .y_out   (cordic_y)
    );

    bpsp_outbuf u_outbuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_in  (cordic_ctl),
        .x_in    (cordic_x),
        .y_in    (cordic_y),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_cos   (m_phasor_cos),
        .m_sin   (m_phasor_sin),
        .pipe_en (pipe_en)
    );

    // Saturation never lets the negative full-scale code through.
    `ASSERT_IMPLIES(a_no_full_scale, aclk, aresetn, m_valid, (m_phasor_cos != 16'sh8000) && (m_phasor_sin != 16'sh8000))

    // The skid register only fills behind an occupied output register.
    `ASSERT_IMPLIES(a_skid_behind_out, aclk, aresetn, !s_ready, m_valid)

    // A full skid register drains in the cycle the receiver takes a result.
    `ASSERT_NEXT(a_skid_drains, aclk, aresetn, m_valid && m_ready && !s_ready, s_ready)

endmodule

`default_nettype wire

// ===== hw/rtl/bpsp_phase.sv =====
// ----------------------------------------------------------------------------
// bpsp_phase
// Two stages: the three products, then their sum, the fractional turn and
// the fold into the quarter-turn range of the CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsp_phase (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [31:0]   u_in,
    input  wire logic signed [31:0]   v_in,
    input  wire logic signed [31:0]   w_in,
    input  wire logic signed [31:0]   l_in,
    input  wire logic signed [31:0]   m_in,
    input  wire logic signed [31:0]   n_in,
    output bpsp_pkg::bpsp_ctl_t       ctl_out,
    output bpsp_pkg::word_t           z_out
);

    logic signed [63:0] p_ul;
    logic signed [63:0] p_vm;
    logic signed [64:0] p_wn;
    logic signed [32:0] n_minus_one;

    logic             valid1_reg;
    bpsp_pkg::prod_t  p_ul_reg, p_vm_reg, p_wn_reg;

    bpsp_pkg::prod_t    sum;
    logic [31:0]        z_raw;
    logic signed [32:0] z_wide;
    logic signed [32:0] z_fold;
    logic               neg_next;

    bpsp_pkg::bpsp_ctl_t ctl_reg;
    bpsp_pkg::word_t     z_reg;

    assign n_minus_one = $signed({n_in[31], n_in}) - bpsp_pkg::ONE_Q30;
    assign p_ul = u_in * l_in;
    assign p_vm = v_in * m_in;
    assign p_wn = $signed({w_in[31], w_in}) * n_minus_one;

    // Only the fractional bits of the turn count matter, so the sum wraps.
    assign sum   = p_ul_reg + p_vm_reg + p_wn_reg;
    assign z_raw = sum[bpsp_pkg::PRODUCT_FRAC_BITS-1 -: 32] & bpsp_pkg::PHASE_MASK;
    assign z_wide = $signed({z_raw[31], z_raw});

    always_comb begin
        z_fold   = z_wide;
        neg_next = 1'b0;
        if (z_wide > bpsp_pkg::ONE_Q30) begin
            z_fold   = z_wide - bpsp_pkg::HALF_TURN;
            neg_next = 1'b1;
        end else if (z_wide < -bpsp_pkg::ONE_Q30) begin
            z_fold   = z_wide + bpsp_pkg::HALF_TURN;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            ctl_reg    <= '0;
        end else if (en) begin
            valid1_reg    <= in_valid;
            ctl_reg.valid <= valid1_reg;
            ctl_reg.neg   <= neg_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_ul_reg <= p_ul[bpsp_pkg::PRODUCT_FRAC_BITS-1:0];
            p_vm_reg <= p_vm[bpsp_pkg::PRODUCT_FRAC_BITS-1:0];
            p_wn_reg <= p_wn[bpsp_pkg::PRODUCT_FRAC_BITS-1:0];
            z_reg    <= z_fold[31:0];
        end
    end

    assign ctl_out = ctl_reg;
    assign z_out   = z_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bpsp_cordic.sv =====
// ----------------------------------------------------------------------------
// bpsp_cordic
// Rotation-mode CORDIC, one registered micro-rotation per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsp_cordic (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire bpsp_pkg::bpsp_ctl_t  ctl_in,
    input  wire bpsp_pkg::word_t      z_in,
    output bpsp_pkg::bpsp_ctl_t       ctl_out,
    output bpsp_pkg::word_t           x_out,
    output bpsp_pkg::word_t           y_out
);

    localparam int N = bpsp_pkg::CORDIC_N;

    bpsp_pkg::word_t     x_reg   [N];
    bpsp_pkg::word_t     y_reg   [N];
    bpsp_pkg::word_t     z_reg   [N];
    bpsp_pkg::bpsp_ctl_t ctl_reg [N];

    for (genvar i = 0; i < N; i++) begin : g_stage
        bpsp_pkg::word_t     x_prev, y_prev, z_prev;
        bpsp_pkg::bpsp_ctl_t ctl_prev;
        bpsp_pkg::word_t     x_next, y_next, z_next;
        bpsp_pkg::word_t     dx, dy;

        if (i == 0) begin : g_first
            assign x_prev   = bpsp_pkg::CORDIC_X0;
            assign y_prev   = '0;
            assign z_prev   = z_in;
            assign ctl_prev = ctl_in;
        end else begin : g_rest
            assign x_prev   = x_reg[i-1];
            assign y_prev   = y_reg[i-1];
            assign z_prev   = z_reg[i-1];
            assign ctl_prev = ctl_reg[i-1];
        end

        assign dx = y_prev >>> i;
        assign dy = x_prev >>> i;

        always_comb begin
            if (!z_prev[31]) begin
                x_next = x_prev - dx;
                y_next = y_prev + dy;
                z_next = z_prev - bpsp_pkg::ATAN_TURNS[i];
            end else begin
                x_next = x_prev + dx;
                y_next = y_prev - dy;
                z_next = z_prev + bpsp_pkg::ATAN_TURNS[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[i] <= '0;
            end else if (en) begin
                ctl_reg[i] <= ctl_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
            end
        end
    end

    assign ctl_out = ctl_reg[N-1];
    assign x_out   = x_reg[N-1];
    assign y_out   = y_reg[N-1];

endmodule

`default_nettype wire

// ===== hw/rtl/bpsp_outbuf.sv =====
// ----------------------------------------------------------------------------
// bpsp_outbuf
// Rounds and saturates the CORDIC result to Q1.15 and holds it in the
// output register, with a one-entry skid register behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsp_outbuf (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire bpsp_pkg::bpsp_ctl_t  ctl_in,
    input  wire bpsp_pkg::word_t      x_in,
    input  wire bpsp_pkg::word_t      y_in,
    input  wire logic                 m_ready,
    output logic                      m_valid,
    output bpsp_pkg::sample_t         m_cos,
    output bpsp_pkg::sample_t         m_sin,
    output logic                      pipe_en
);

    function automatic bpsp_pkg::sample_t to_q15(input bpsp_pkg::word_t v,
                                                 input logic neg);
        logic signed [32:0] vx;
        logic signed [32:0] rnd;
        begin
            vx  = neg ? -$signed({v[31], v}) : $signed({v[31], v});
            rnd = (vx + bpsp_pkg::ROUND_Q15) >>> 15;
            if (rnd > bpsp_pkg::OUT_MAX) begin
                return bpsp_pkg::OUT_MAX[15:0];
            end else if (rnd < -bpsp_pkg::OUT_MAX) begin
                return -bpsp_pkg::OUT_MAX[15:0];
            end
            return rnd[15:0];
        end
    endfunction

    bpsp_pkg::sample_t cos_rnd, sin_rnd;

    logic              m_valid_reg, m_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    bpsp_pkg::sample_t cos_reg, cos_next, sin_reg, sin_next;
    bpsp_pkg::sample_t skid_cos_reg, skid_sin_reg;
    logic              load_out, load_skid;

    assign cos_rnd = to_q15(x_in, ctl_in.neg);
    assign sin_rnd = to_q15(y_in, ctl_in.neg);

    // While the skid register is full the pipeline is frozen, and only the
    // skid can move forward.
    always_comb begin
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        cos_next        = cos_rnd;
        sin_next        = sin_rnd;
        if (skid_valid_reg) begin
            cos_next = skid_cos_reg;
            sin_next = skid_sin_reg;
            if (m_ready) begin
                load_out        = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (!m_valid_reg || m_ready) begin
            load_out     = 1'b1;
            m_valid_next = ctl_in.valid;
        end else if (ctl_in.valid) begin
            load_skid       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
        if (load_skid) begin
            skid_cos_reg <= cos_rnd;
            skid_sin_reg <= sin_rnd;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_cos   = cos_reg;
    assign m_sin   = sin_reg;
    assign pipe_en = !skid_valid_reg;

endmodule

`default_nettype wire

// ===== dv/bpsp_checker.sv =====
// ----------------------------------------------------------------------------
// bpsp_checker
// Watches both channels of the baseline phasor, computes the expected cos and
// sin for every accepted request and compares them, in order, with the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpsp_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic signed [31:0] s_u_wavelengths,
    input  wire logic signed [31:0] s_v_wavelengths,
    input  wire logic signed [31:0] s_w_wavelengths,
    input  wire logic signed [31:0] s_dir_l,
    input  wire logic signed [31:0] s_dir_m,
    input  wire logic signed [31:0] s_dir_n,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic signed [15:0] m_phasor_cos,
    input  wire logic signed [15:0] m_phasor_sin,
    output int                      mismatches,
    output int                      pending
);

    typedef struct packed {
        bpsp_pkg::sample_t re;
        bpsp_pkg::sample_t im;
    } phasor_t;

    phasor_t phasor_q[$];

    // Q2.30 to Q1.15 with round half up, clamped to +-32767.
    function automatic bpsp_pkg::sample_t round_q15(longint val);
        longint r;
        r = (val + 64'sd16384) >>> 15;
        if (r > 64'sd32767)
            r = 64'sd32767;
        if (r < -64'sd32767)
            r = -64'sd32767;
        return bpsp_pkg::sample_t'(r);
    endfunction

    function automatic phasor_t rotate_baseline(
        bpsp_pkg::word_t u, bpsp_pkg::word_t v, bpsp_pkg::word_t w,
        bpsp_pkg::word_t l, bpsp_pkg::word_t m, bpsp_pkg::word_t n);
        longint      acc;
        longint      n_minus_one;
        longint      z;
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        logic [63:0] frac;
        logic [31:0] turn;
        bit          flip;
        phasor_t     res;
        n_minus_one = longint'(n) - 64'sd1073741824;
        // Products wrap modulo 2^64; only the fractional turn survives anyway.
        acc = longint'(u) * longint'(l) + longint'(v) * longint'(m)
            + longint'(w) * n_minus_one;
        frac = acc;
        frac = (frac >> (bpsp_pkg::PRODUCT_FRAC_BITS - bpsp_pkg::PHASE_FRAC_BITS))
             & ((64'd1 << bpsp_pkg::PHASE_FRAC_BITS) - 64'd1);
        turn = 32'(frac << (32 - bpsp_pkg::PHASE_FRAC_BITS));
        z = longint'(signed'(turn));
        flip = 1'b0;
        if (z > 64'sd1073741824) begin
            z = z - 64'sd2147483648;
            flip = 1'b1;
        end else if (z < -64'sd1073741824) begin
            z = z + 64'sd2147483648;
            flip = 1'b1;
        end
        x = longint'(bpsp_pkg::CORDIC_X0);
        y = 0;
        for (int i = 0; i < bpsp_pkg::CORDIC_N; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(bpsp_pkg::ATAN_TURNS[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(bpsp_pkg::ATAN_TURNS[i]);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        res.re = round_q15(x);
        res.im = round_q15(y);
        return res;
    endfunction

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        phasor_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (phasor_q.size() == 0) begin
                    $error("result with no request outstanding: cos %0d sin %0d",
                           m_phasor_cos, m_phasor_sin);
                    mismatches++;
                end else begin
                    want = phasor_q.pop_front();
                    if (m_phasor_cos !== want.re) begin
                        $error("phasor_cos: expected %0d, actual %0d",
                               want.re, m_phasor_cos);
                        mismatches++;
                    end
                    if (m_phasor_sin !== want.im) begin
                        $error("phasor_sin: expected %0d, actual %0d",
                               want.im, m_phasor_sin);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready)
                phasor_q.push_back(rotate_baseline(s_u_wavelengths, s_v_wavelengths,
                                                   s_w_wavelengths, s_dir_l,
                                                   s_dir_m, s_dir_n));
        end
        pending = phasor_q.size();
    end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives baseline and direction requests into the phasor block, with random
// gaps and result-side back-pressure, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_RANDOM = 700;
    localparam int DRAIN_WAIT = 3 * (3 + bpsp_pkg::CORDIC_STAGES);
    localparam bpsp_pkg::word_t ONE_DIR     = 32'sd1073741824;
    localparam bpsp_pkg::word_t QUARTER_DIR = 32'sd268435456;
    localparam bpsp_pkg::word_t ONE_WAVE    = 32'sd256;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    bpsp_pkg::word_t s_u_wavelengths;
    bpsp_pkg::word_t s_v_wavelengths;
    bpsp_pkg::word_t s_w_wavelengths;
    bpsp_pkg::word_t s_dir_l;
    bpsp_pkg::word_t s_dir_m;
    bpsp_pkg::word_t s_dir_n;
    logic  m_valid;
    logic  m_ready;
    bpsp_pkg::sample_t m_phasor_cos;
    bpsp_pkg::sample_t m_phasor_sin;

    int mismatches;
    int pending;
    int sender_idle_pct;
    int receiver_idle_pct;

    baseline_phase_shift_phasor dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_u_wavelengths (s_u_wavelengths),
        .s_v_wavelengths (s_v_wavelengths),
        .s_w_wavelengths (s_w_wavelengths),
        .s_dir_l         (s_dir_l),
        .s_dir_m         (s_dir_m),
        .s_dir_n         (s_dir_n),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_phasor_cos    (m_phasor_cos),
        .m_phasor_sin    (m_phasor_sin)
    );

    bpsp_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_u_wavelengths (s_u_wavelengths),
        .s_v_wavelengths (s_v_wavelengths),
        .s_w_wavelengths (s_w_wavelengths),
        .s_dir_l         (s_dir_l),
        .s_dir_m         (s_dir_m),
        .s_dir_n         (s_dir_n),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_phasor_cos    (m_phasor_cos),
        .m_phasor_sin    (m_phasor_sin),
        .mismatches      (mismatches),
        .pending         (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Result-side back-pressure, changed on the falling edge only.
    always @(negedge aclk) begin
        m_ready <= (receiver_idle_pct == 0) || ($urandom_range(99) >= receiver_idle_pct);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input bpsp_pkg::word_t u, input bpsp_pkg::word_t v,
                                input bpsp_pkg::word_t w, input bpsp_pkg::word_t l,
                                input bpsp_pkg::word_t m, input bpsp_pkg::word_t n);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_u_wavelengths <= u;
        s_v_wavelengths <= v;
        s_w_wavelengths <= w;
        s_dir_l         <= l;
        s_dir_m         <= m;
        s_dir_n         <= n;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
    endtask

    function automatic bpsp_pkg::word_t rand_coord();
        case ($urandom_range(3))
            0:       return bpsp_pkg::word_t'($urandom);
            1:       return bpsp_pkg::word_t'($urandom_range(8192)) - 32'sd4096;
            2:       return bpsp_pkg::word_t'($urandom_range(2_000_000)) - 32'sd1_000_000;
            default: return bpsp_pkg::word_t'($urandom_range(1 << 20)) - 32'sd524288;
        endcase
    endfunction

    function automatic bpsp_pkg::word_t rand_dir();
        case ($urandom_range(5))
            0:       return bpsp_pkg::word_t'($urandom);
            1: begin
                case ($urandom_range(3))
                    0:       return ONE_DIR;
                    1:       return -ONE_DIR;
                    2:       return ONE_DIR - 32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default: return bpsp_pkg::word_t'($urandom_range(32'h8000_0000)) - ONE_DIR;
        endcase
    endfunction

    initial begin
        sender_idle_pct   = 28;
        receiver_idle_pct = 28;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_u_wavelengths = '0;
        s_v_wavelengths = '0;
        s_w_wavelengths = '0;
        s_dir_l         = '0;
        s_dir_m         = '0;
        s_dir_n         = '0;
        m_ready         = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Zero phase, then exact quarter and half turns around the fold points.
        send_request(0, 0, 0, 0, 0, 0);
        send_request(0, 0, 0, 0, 0, ONE_DIR);
        send_request(ONE_WAVE, 0, 0, QUARTER_DIR, 0, ONE_DIR);
        send_request(ONE_WAVE, 0, 0, -QUARTER_DIR, 0, ONE_DIR);
        send_request(ONE_WAVE, 0, 0, 2 * QUARTER_DIR, 0, ONE_DIR);
        send_request(ONE_WAVE, 0, 0, 3 * QUARTER_DIR, 0, ONE_DIR);
        send_request(ONE_WAVE, 0, 0, QUARTER_DIR + 32'sd64, 0, ONE_DIR);
        send_request(ONE_WAVE, 0, 0, QUARTER_DIR - 32'sd64, 0, ONE_DIR);
        send_request(ONE_WAVE, 0, 0, -QUARTER_DIR - 32'sd64, 0, ONE_DIR);
        // Sub-resolution phase is truncated away, then the v and w terms on their own.
        send_request(32'sd1, 0, 0, 32'sd1, 0, ONE_DIR);
        send_request(0, ONE_WAVE, 0, 0, QUARTER_DIR, ONE_DIR);
        send_request(0, 0, ONE_WAVE, 0, 0, ONE_DIR - QUARTER_DIR);
        send_request(0, 0, ONE_WAVE, 0, 0, -ONE_DIR);
        // Field extremes.
        send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     ONE_DIR, ONE_DIR, ONE_DIR);
        send_request(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                     -ONE_DIR, -ONE_DIR, -ONE_DIR);
        send_request(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                     -ONE_DIR, ONE_DIR, -ONE_DIR);
        // Direction cosines outside [-1, 1] are accepted as plain bit patterns.
        send_request(ONE_WAVE, ONE_WAVE, ONE_WAVE,
                     32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_request(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                     32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_request(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
        send_request(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                     32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA);

        wait_drained();

        for (int k = 0; k < NUM_RANDOM; k++) begin
            if (k == 250) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            if (k == 400) begin
                sender_idle_pct   = 28;
                receiver_idle_pct = 28;
            end
            if (k == 550)
                wait_drained();
            send_request(rand_coord(), rand_coord(), rand_coord(),
                         rand_dir(), rand_dir(), rand_dir());
        end

        receiver_idle_pct = 28;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
